@@ rtl/dqsi_pkg.sv @@
package dqsi_pkg;

    localparam int KEY_W    = 32;
    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_POP_FRONT  = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_INSERT     = 3'd4,
        OP_DELETE     = 3'd5
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

endpackage

@@ rtl/dqsi_ram.sv @@
module dqsi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/double_ended_queue_sorted_insert.sv @@
// Bounded double-ended queue of signed 32-bit keys held in one key memory
// with a write port, a read port and a registered read. The block works on
// one transaction at a time and takes a new one only when the previous result
// has gone to the output register. A push or a pop, and a priority insert
// or delete by key that finds its answer at the front or back, needs no
// scan; otherwise the sequencer walks the memory one entry per cycle,
// reading one position while writing the previous one back. A stalled
// result delays the return to idle until it is taken.
module double_ended_queue_sorted_insert #(
    parameter int CAPACITY = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  logic [dqsi_pkg::OPCODE_W-1:0]         opcode,
    input  logic signed [dqsi_pkg::KEY_W-1:0]     key,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic [dqsi_pkg::STATUS_W-1:0]         status,
    output logic signed [dqsi_pkg::KEY_W-1:0]     removed_key,
    output logic [dqsi_pkg::COUNT_W-1:0]          count
);

    import dqsi_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP_F,
        ST_POP_B,
        ST_INS_FRONT,
        ST_INS_BACK,
        ST_SCAN_INS,
        ST_INS_TAIL,
        ST_DEL_FRONT,
        ST_DEL_BACK,
        ST_SCAN_DEL,
        ST_RESP
    } state_t;

    state_t                    state_reg, state_next;
    opcode_t                   op_reg, op_next;
    logic signed [KEY_W-1:0]   key_reg, key_next;
    logic [IW-1:0]             first_reg, first_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [CW-1:0]             pend_reg, pend_next;
    logic                      flag_reg, flag_next;
    logic [KEY_W-1:0]          carry_reg, carry_next;
    status_t                   res_status_reg, res_status_next;
    logic [KEY_W-1:0]          res_removed_reg, res_removed_next;
    logic                      out_valid_reg, out_valid_next;
    status_t                   status_out_reg, status_out_next;
    logic [KEY_W-1:0]          removed_out_reg, removed_out_next;
    logic [COUNT_W-1:0]        count_out_reg, count_out_next;

    logic                      ram_we;
    logic [IW-1:0]             ram_waddr;
    logic [KEY_W-1:0]          ram_wdata;
    logic                      ram_re;
    logic [IW-1:0]             ram_raddr;
    logic [KEY_W-1:0]          ram_rdata;
    logic signed [KEY_W-1:0]   rd_key;

    logic                      full;
    logic                      empty;
    logic                      last;
    logic                      out_free;
    logic [IW-1:0]             first_dec;
    logic [IW-1:0]             first_inc;
    logic [CW+COUNT_W-1:0]     count_ext;

    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] first,
                                              input logic [CW-1:0] pos);
        logic [CW:0] sum;
        sum = (CW+1)'(first) + (CW+1)'(pos);
        if (sum >= (CW+1)'(CAPACITY))
        begin
            sum = sum - (CW+1)'(CAPACITY);
        end
        return sum[IW-1:0];
    endfunction

    dqsi_ram #(
        .WIDTH(KEY_W),
        .DEPTH(CAPACITY)
    ) u_key_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_key    = $signed(ram_rdata);
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign last      = (pend_reg == count_reg - CW'(1));
    assign out_free  = !out_valid_reg || !result_stall;
    assign first_dec = (first_reg == '0) ? IW'(CAPACITY - 1) : first_reg - IW'(1);
    assign first_inc = (first_reg == IW'(CAPACITY - 1)) ? '0 : first_reg + IW'(1);
    assign count_ext = {{COUNT_W{1'b0}}, count_reg};

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;
    assign status       = status_out_reg;
    assign removed_key  = $signed(removed_out_reg);
    assign count        = count_out_reg;

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        first_next       = first_reg;
        count_next       = count_reg;
        pend_next        = pend_reg;
        flag_next        = flag_reg;
        carry_next       = carry_reg;
        res_status_next  = res_status_reg;
        res_removed_next = res_removed_reg;
        out_valid_next   = out_valid_reg;
        status_out_next  = status_out_reg;
        removed_out_next = removed_out_reg;
        count_out_next   = count_out_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = key_reg;
        ram_re           = 1'b0;
        ram_raddr        = '0;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    op_next    = opcode_t'(opcode);
                    key_next   = key;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                res_status_next  = STAT_OK;
                res_removed_next = '0;
                state_next       = ST_RESP;
                case (op_reg)
                    OP_PUSH_BACK:
                    begin
                        if (full)
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = slot_of(first_reg, count_reg);
                            count_next = count_reg + CW'(1);
                        end
                    end
                    OP_PUSH_FRONT:
                    begin
                        if (full)
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = first_dec;
                            first_next = first_dec;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    OP_POP_FRONT:
                    begin
                        if (empty)
                        begin
                            res_status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = first_reg;
                            state_next = ST_POP_F;
                        end
                    end
                    OP_POP_BACK:
                    begin
                        if (empty)
                        begin
                            res_status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = slot_of(first_reg, count_reg - CW'(1));
                            state_next = ST_POP_B;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (full)
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else if (empty)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = first_dec;
                            first_next = first_dec;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = first_reg;
                            state_next = ST_INS_FRONT;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (empty)
                        begin
                            res_status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = first_reg;
                            state_next = ST_DEL_FRONT;
                        end
                    end
                    default:
                    begin
                        res_status_next = STAT_OK;
                    end
                endcase
            end

            ST_POP_F:
            begin
                res_removed_next = ram_rdata;
                first_next       = first_inc;
                count_next       = count_reg - CW'(1);
                state_next       = ST_RESP;
            end

            ST_POP_B:
            begin
                res_removed_next = ram_rdata;
                count_next       = count_reg - CW'(1);
                state_next       = ST_RESP;
            end

            ST_INS_FRONT:
            begin
                if (!(rd_key < key_reg))
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = first_dec;
                    first_next = first_dec;
                    count_next = count_reg + CW'(1);
                    state_next = ST_RESP;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = slot_of(first_reg, count_reg - CW'(1));
                    state_next = ST_INS_BACK;
                end
            end

            ST_INS_BACK:
            begin
                if (!(key_reg < rd_key))
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = slot_of(first_reg, count_reg);
                    count_next = count_reg + CW'(1);
                    state_next = ST_RESP;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = slot_of(first_reg, CW'(1));
                    pend_next  = CW'(1);
                    flag_next  = 1'b0;
                    state_next = ST_SCAN_INS;
                end
            end

            // The key goes in at the first entry that is not less than it,
            // or at the last entry at the latest; later entries ripple back.
            ST_SCAN_INS:
            begin
                if (!last)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = slot_of(first_reg, pend_reg + CW'(1));
                    pend_next = pend_reg + CW'(1);
                end
                if (flag_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = slot_of(first_reg, pend_reg);
                    ram_wdata  = carry_reg;
                    carry_next = ram_rdata;
                end
                else if (last || !(rd_key < key_reg))
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = slot_of(first_reg, pend_reg);
                    ram_wdata  = key_reg;
                    carry_next = ram_rdata;
                    flag_next  = 1'b1;
                end
                if (last)
                begin
                    state_next = ST_INS_TAIL;
                end
            end

            ST_INS_TAIL:
            begin
                ram_we     = 1'b1;
                ram_waddr  = slot_of(first_reg, count_reg);
                ram_wdata  = carry_reg;
                count_next = count_reg + CW'(1);
                state_next = ST_RESP;
            end

            ST_DEL_FRONT:
            begin
                if (rd_key == key_reg)
                begin
                    res_removed_next = ram_rdata;
                    first_next       = first_inc;
                    count_next       = count_reg - CW'(1);
                    state_next       = ST_RESP;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = slot_of(first_reg, count_reg - CW'(1));
                    state_next = ST_DEL_BACK;
                end
            end

            ST_DEL_BACK:
            begin
                if (rd_key == key_reg)
                begin
                    res_removed_next = ram_rdata;
                    count_next       = count_reg - CW'(1);
                    state_next       = ST_RESP;
                end
                else if (count_reg == CW'(1))
                begin
                    res_status_next = STAT_NOT_FOUND;
                    state_next      = ST_RESP;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = slot_of(first_reg, CW'(1));
                    pend_next  = CW'(1);
                    flag_next  = 1'b0;
                    state_next = ST_SCAN_DEL;
                end
            end

            // Once the key is found, each later entry moves one place forward.
            ST_SCAN_DEL:
            begin
                if (!last)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = slot_of(first_reg, pend_reg + CW'(1));
                    pend_next = pend_reg + CW'(1);
                end
                if (flag_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_of(first_reg, pend_reg - CW'(1));
                    ram_wdata = ram_rdata;
                end
                else if (rd_key == key_reg)
                begin
                    flag_next = 1'b1;
                end
                if (last)
                begin
                    if (flag_reg || rd_key == key_reg)
                    begin
                        res_removed_next = key_reg;
                        count_next       = count_reg - CW'(1);
                    end
                    else
                    begin
                        res_status_next = STAT_NOT_FOUND;
                    end
                    state_next = ST_RESP;
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    status_out_next  = res_status_reg;
                    removed_out_next = res_removed_reg;
                    count_out_next   = count_ext[COUNT_W-1:0];
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_PUSH_BACK;
            key_reg         <= '0;
            first_reg       <= '0;
            count_reg       <= '0;
            pend_reg        <= '0;
            flag_reg        <= 1'b0;
            carry_reg       <= '0;
            res_status_reg  <= STAT_OK;
            res_removed_reg <= '0;
            out_valid_reg   <= 1'b0;
            status_out_reg  <= STAT_OK;
            removed_out_reg <= '0;
            count_out_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            key_reg         <= key_next;
            first_reg       <= first_next;
            count_reg       <= count_next;
            pend_reg        <= pend_next;
            flag_reg        <= flag_next;
            carry_reg       <= carry_next;
            res_status_reg  <= res_status_next;
            res_removed_reg <= res_removed_next;
            out_valid_reg   <= out_valid_next;
            status_out_reg  <= status_out_next;
            removed_out_reg <= removed_out_next;
            count_out_reg   <= count_out_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("Entry count exceeds the capacity.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |->
            (count_reg == $past(count_reg) + CW'(1)) ||
            (count_reg == $past(count_reg) - CW'(1)))
        else $error("Entry count moved by more than one in a transaction.");

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && ram_re |-> ram_waddr != ram_raddr)
        else $error("Key memory read and written at the same entry in one cycle.");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !ram_we && !ram_re)
        else $error("Key memory accessed while no transaction is in progress.");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RESP && out_free |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("Finished transaction did not reach the output register.");

endmodule
